[src/assert_macros.svh]
// assertion macros shared by the rtl
// expects clk and rst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/fpa_pkg.sv]
// types, codes and defaults for the flash page allocator
// no dependencies
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int NUM_AREAS_DEF  = 16;
  localparam int AREA_PAGES_DEF = 64;
  localparam int NUM_TYPES_DEF  = 4;

  typedef enum logic [1:0] {
    REG_AREAS_IN_USE  = 2'd0,
    REG_PAGES_IN_USE  = 2'd1,
    REG_AREA_TYPE_MAP = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AS_EMPTY  = 2'd0,
    AS_ACTIVE = 2'd1,
    AS_CLOSED = 2'd2
  } area_st_t;

  typedef enum logic [1:0] {
    PG_FREE  = 2'd0,
    PG_USED  = 2'd1,
    PG_DIRTY = 2'd2
  } page_st_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_DIRTY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    RS_OK      = 2'd0,
    RS_NOSPACE = 2'd1,
    RS_NOROOM  = 2'd2
  } res_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_ASCAN,
    ST_OPEN,
    ST_PSCAN,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    logic       cmd;
    logic [1:0] area_type;
    logic [3:0] area_index;
    logic [5:0] page_index;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] out_area;
    logic [5:0] out_page;
    logic       area_closed;
  } out_t;

endpackage

[src/flash_page_allocator.sv]
// A mark-dirty request goes straight to the result. An allocate from a live cached area
// checks its status and scans its pages in use; a cache miss adds an area scan over
// areas_in_use, opening an empty area adds a clear sweep of all AREA_PAGES pages, and
// filling an area adds one more area scan, plus a sweep when that opens an empty area.
// Throughput: one transaction at a time, bound by the one-entry-per-cycle status and page
// memory reads. Reset clears control and the per-area valid bits and sets the config
// registers to their defaults; page memory is not cleared, each area is swept when opened.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module flash_page_allocator
  import fpa_pkg::*;
#(
  parameter int NUM_AREAS  = NUM_AREAS_DEF,
  parameter int AREA_PAGES = AREA_PAGES_DEF,
  parameter int NUM_TYPES  = NUM_TYPES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW  = $clog2(NUM_AREAS);
  localparam int ACW = $clog2(NUM_AREAS + 1);
  localparam int PGW = $clog2(AREA_PAGES);
  localparam int PCW = $clog2(AREA_PAGES + 1);
  localparam int MAW = $clog2(NUM_AREAS * AREA_PAGES);
  localparam int TW  = $clog2(NUM_TYPES);

  // config
  logic [4:0]  areas_r;
  logic [6:0]  pages_r;
  logic [31:0] map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      areas_r <= 5'd16;
      pages_r <= 7'd64;
      map_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREAS_IN_USE:  areas_r <= cfg_wdata[4:0];
        REG_PAGES_IN_USE:  pages_r <= cfg_wdata[6:0];
        REG_AREA_TYPE_MAP: map_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [ACW-1:0] n_areas;
  logic [PCW-1:0] n_pages;
  assign n_areas = (32'(areas_r) > NUM_AREAS) ? ACW'(NUM_AREAS) : ACW'(areas_r);
  assign n_pages = (pages_r == 7'd0) ? PCW'(1) :
                   (32'(pages_r) > AREA_PAGES) ? PCW'(AREA_PAGES) : PCW'(pages_r);

  // state
  fsm_t           state_r, state_nxt;
  logic [1:0]     typ_r, typ_nxt;
  logic [AW-1:0]  cur_a_r, cur_a_nxt;
  logic [ACW-1:0] sc_r, sc_nxt;
  logic [PCW-1:0] pc_r, pc_nxt;
  logic           pv_r, pv_nxt;
  logic [AW-1:0]  aidx_r, aidx_nxt;
  logic [PGW-1:0] pgi_r, pgi_nxt;
  logic           emp_fnd_r, emp_fnd_nxt;
  logic [AW-1:0]  emp_a_r, emp_a_nxt;
  logic           ff_fnd_r, ff_fnd_nxt;
  logic [PGW-1:0] ff_p_r, ff_p_nxt;
  logic           free2_r, free2_nxt;
  logic           after_r, after_nxt;
  out_t           res_r, res_nxt;
  out_t           out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [AW-1:0]  act_area_r [NUM_TYPES];
  logic [AW-1:0]  act_area_nxt [NUM_TYPES];
  logic           act_vld_r [NUM_TYPES];
  logic           act_vld_nxt [NUM_TYPES];
  logic           sv_r [NUM_AREAS];
  logic           stv_r;

  // memory ports
  logic           st_we;
  logic [AW-1:0]  st_waddr, st_raddr;
  logic [1:0]     st_wdata, st_q;
  logic           pg_we;
  logic [MAW-1:0] pg_waddr, pg_raddr;
  logic [1:0]     pg_wdata, pg_q;
  logic [1:0]     stat;
  logic [1:0]     map_typ;
  logic           out_load;

  fpa_ram #(.W(2), .D(NUM_AREAS)) u_status_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_q)
  );

  fpa_ram #(.W(2), .D(NUM_AREAS * AREA_PAGES)) u_page_ram (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
    .raddr(pg_raddr), .rdata(pg_q)
  );

  assign stat    = stv_r ? st_q : AS_EMPTY;
  assign map_typ = map_r[{4'(aidx_r), 1'b0} +: 2];

  function automatic logic [MAW-1:0] page_addr(input logic [AW-1:0] a,
                                               input logic [PGW-1:0] p);
    return MAW'(a) * MAW'(AREA_PAGES) + MAW'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      stv_r       <= 1'b0;
      for (int i = 0; i < NUM_TYPES; i++) act_vld_r[i] <= 1'b0;
      for (int i = 0; i < NUM_AREAS; i++) sv_r[i] <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      stv_r       <= sv_r[st_raddr];
      for (int i = 0; i < NUM_TYPES; i++) act_vld_r[i] <= act_vld_nxt[i];
      if (st_we) sv_r[st_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    typ_r     <= typ_nxt;
    cur_a_r   <= cur_a_nxt;
    sc_r      <= sc_nxt;
    pc_r      <= pc_nxt;
    pv_r      <= pv_nxt;
    aidx_r    <= aidx_nxt;
    pgi_r     <= pgi_nxt;
    emp_fnd_r <= emp_fnd_nxt;
    emp_a_r   <= emp_a_nxt;
    ff_fnd_r  <= ff_fnd_nxt;
    ff_p_r    <= ff_p_nxt;
    free2_r   <= free2_nxt;
    after_r   <= after_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    for (int i = 0; i < NUM_TYPES; i++) act_area_r[i] <= act_area_nxt[i];
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    typ_nxt       = typ_r;
    cur_a_nxt     = cur_a_r;
    sc_nxt        = sc_r;
    pc_nxt        = pc_r;
    pv_nxt        = pv_r;
    aidx_nxt      = aidx_r;
    pgi_nxt       = pgi_r;
    emp_fnd_nxt   = emp_fnd_r;
    emp_a_nxt     = emp_a_r;
    ff_fnd_nxt    = ff_fnd_r;
    ff_p_nxt      = ff_p_r;
    free2_nxt     = free2_r;
    after_nxt     = after_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      act_area_nxt[i] = act_area_r[i];
      act_vld_nxt[i]  = act_vld_r[i];
    end
    st_we    = 1'b0;
    st_waddr = cur_a_r;
    st_wdata = AS_CLOSED;
    st_raddr = cur_a_r;
    pg_we    = 1'b0;
    pg_waddr = page_addr(cur_a_r, ff_p_r);
    pg_wdata = PG_USED;
    pg_raddr = page_addr(cur_a_r, pc_r[PGW-1:0]);

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          typ_nxt = in_data.area_type;
          res_nxt = '0;
          if (in_data.cmd == CMD_DIRTY) begin
            if (32'(in_data.area_index) < NUM_AREAS &&
                32'(in_data.page_index) < AREA_PAGES) begin
              pg_we    = 1'b1;
              pg_waddr = page_addr(AW'(in_data.area_index), PGW'(in_data.page_index));
              pg_wdata = PG_DIRTY;
            end
            state_nxt = ST_DONE;
          end else if (32'(in_data.area_type) >= NUM_TYPES) begin
            res_nxt.status = RS_NOSPACE;
            state_nxt      = ST_DONE;
          end else if (act_vld_r[TW'(in_data.area_type)]) begin
            st_raddr  = act_area_r[TW'(in_data.area_type)];
            cur_a_nxt = act_area_r[TW'(in_data.area_type)];
            state_nxt = ST_CHK;
          end else begin
            sc_nxt      = '0;
            pv_nxt      = 1'b0;
            emp_fnd_nxt = 1'b0;
            after_nxt   = 1'b0;
            state_nxt   = ST_ASCAN;
          end
        end
      end

      ST_CHK: begin
        if (stat != AS_CLOSED) begin
          pc_nxt     = '0;
          pv_nxt     = 1'b0;
          ff_fnd_nxt = 1'b0;
          free2_nxt  = 1'b0;
          state_nxt  = ST_PSCAN;
        end else begin
          sc_nxt      = '0;
          pv_nxt      = 1'b0;
          emp_fnd_nxt = 1'b0;
          after_nxt   = 1'b0;
          state_nxt   = ST_ASCAN;
        end
      end

      ST_ASCAN: begin
        if (pv_r && map_typ == typ_r && stat == AS_ACTIVE) begin
          cur_a_nxt                   = aidx_r;
          act_area_nxt[TW'(typ_r)]    = aidx_r;
          act_vld_nxt[TW'(typ_r)]     = 1'b1;
          pc_nxt                      = '0;
          pv_nxt                      = 1'b0;
          ff_fnd_nxt                  = 1'b0;
          free2_nxt                   = 1'b0;
          state_nxt                   = after_r ? ST_DONE : ST_PSCAN;
        end else begin
          if (pv_r && map_typ == typ_r && stat == AS_EMPTY && !emp_fnd_r) begin
            emp_fnd_nxt = 1'b1;
            emp_a_nxt   = aidx_r;
          end
          if (sc_r < n_areas) begin
            st_raddr = sc_r[AW-1:0];
            aidx_nxt = sc_r[AW-1:0];
            pv_nxt   = 1'b1;
            sc_nxt   = sc_r + ACW'(1);
          end else begin
            pv_nxt = 1'b0;
            if (!pv_r) begin
              if (emp_fnd_r) begin
                cur_a_nxt = emp_a_r;
                st_we     = 1'b1;
                st_waddr  = emp_a_r;
                st_wdata  = AS_ACTIVE;
                pc_nxt    = '0;
                state_nxt = ST_OPEN;
              end else begin
                act_vld_nxt[TW'(typ_r)] = 1'b0;
                res_nxt.status          = after_r ? RS_NOROOM : RS_NOSPACE;
                state_nxt               = ST_DONE;
              end
            end
          end
        end
      end

      // clear sweep of a newly opened area
      ST_OPEN: begin
        pg_we    = 1'b1;
        pg_waddr = page_addr(cur_a_r, pc_r[PGW-1:0]);
        pg_wdata = PG_FREE;
        pc_nxt   = pc_r + PCW'(1);
        if (pc_r == PCW'(AREA_PAGES - 1)) begin
          act_area_nxt[TW'(typ_r)] = cur_a_r;
          act_vld_nxt[TW'(typ_r)]  = 1'b1;
          pc_nxt                   = '0;
          pv_nxt                   = 1'b0;
          ff_fnd_nxt               = 1'b0;
          free2_nxt                = 1'b0;
          state_nxt                = after_r ? ST_DONE : ST_PSCAN;
        end
      end

      ST_PSCAN: begin
        if (pv_r && pg_q == PG_FREE) begin
          if (!ff_fnd_r) begin
            ff_fnd_nxt = 1'b1;
            ff_p_nxt   = pgi_r;
          end else begin
            free2_nxt = 1'b1;
          end
        end
        if (pc_r < n_pages) begin
          pgi_nxt = pc_r[PGW-1:0];
          pv_nxt  = 1'b1;
          pc_nxt  = pc_r + PCW'(1);
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            if (!ff_fnd_r) begin
              st_we                   = 1'b1;
              act_vld_nxt[TW'(typ_r)] = 1'b0;
              res_nxt.status          = RS_NOSPACE;
              state_nxt               = ST_DONE;
            end else begin
              pg_we            = 1'b1;
              res_nxt.status   = RS_OK;
              res_nxt.out_area = 4'(cur_a_r);
              res_nxt.out_page = 6'(ff_p_r);
              if (!free2_r) begin
                st_we               = 1'b1;
                res_nxt.area_closed = 1'b1;
                after_nxt           = 1'b1;
                sc_nxt              = '0;
                emp_fnd_nxt         = 1'b0;
                state_nxt           = ST_ASCAN;
              end else begin
                state_nxt = ST_DONE;
              end
            end
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  for (genvar k = 0; k < NUM_TYPES; k++) begin : g_cache_chk
    `FPA_ASSERT_IMP(a_cache_open, act_vld_r[k], sv_r[act_area_r[k]], "cached area never opened")
  end

  `FPA_ASSERT_IMP(a_pscan_open, state_r == ST_PSCAN, sv_r[cur_a_r], "page scan of unopened area")
  `FPA_ASSERT_NXT(a_done_load, out_load, out_valid_r && state_r == ST_IDLE, "result not loaded")

endmodule

[src/fpa_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module fpa_ram #(
  parameter int W = 2,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
